>>> rtl/dgag_pkg.sv
// shared types and constants for the double-byte glyph address generator
// no dependencies; imported by every rtl module of the block except dgag_checker
package dgag_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FONT_LOADED  = 3'd0,
    REG_ASCII_WIDTH  = 3'd1,
    REG_CJK_WIDTH    = 3'd2,
    REG_GLYPH_HEIGHT = 3'd3,
    REG_ASCII_OFFSET = 3'd4,
    REG_CJK_OFFSET   = 3'd5
  } reg_idx_e;

  // text decoding constants
  localparam logic [7:0]  LeadMask    = 8'h80;
  localparam logic [7:0]  RowBase     = 8'hA1;
  localparam logic [7:0]  CellsPerRow = 8'd94;
  // bitmap size saturation limit
  localparam logic [9:0]  GlyphMaxBytes = 10'd128;
  // dimension clamp limits
  localparam logic [5:0]  DimMax = 6'd32;

  // configuration register file contents
  typedef struct packed {
    logic        font_loaded;
    logic [5:0]  ascii_width;
    logic [5:0]  cjk_width;
    logic [5:0]  glyph_height;
    logic [31:0] ascii_offset;
    logic [31:0] cjk_offset;
  } cfg_t;

  // one multiply-add command for the shared unit: a * b + addend
  typedef struct packed {
    logic [15:0] a;       // signed multiplicand
    logic [7:0]  b;       // unsigned multiplier
    logic [31:0] addend;  // added modulo 2^32
  } mac_op_t;

  // one glyph fetch request
  typedef struct packed {
    logic [15:0] next_x;
    logic        is_wide;
    logic [1:0]  mode_out;
    logic [7:0]  pos_y;
    logic [15:0] pos_x;
    logic [5:0]  glyph_width;
    logic [7:0]  glyph_bytes;
    logic [31:0] glyph_offset;
  } glyph_req_t;

endpackage

>>> rtl/dgag_mac.sv
// shared multiply-add unit with registered result
// depends on dgag_pkg for the command struct
module dgag_mac import dgag_pkg::*; (
  input  logic        clk_i,
  input  mac_op_t     op_i,
  output logic [31:0] res_o
);

  logic signed [24:0] prod;
  logic [31:0]        res_d;
  logic [31:0]        res_q;

  // signed 16 x unsigned 8 product, sign extended and added modulo 2^32
  assign prod  = $signed(op_i.a) * $signed({1'b0, op_i.b});
  assign res_d = {{7{prod[24]}}, prod} + op_i.addend;

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> rtl/dgag_ctrl.sv
// sequencer: byte decoding, pen and lead-byte state, shared unit control, result register
// depends on dgag_pkg; drives the dgag_mac unit through a mac_op_t command
module dgag_ctrl import dgag_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  input  logic        string_start_i,
  input  logic [15:0] start_x_i,
  input  logic [7:0]  row_y_i,
  input  logic [1:0]  draw_mode_i,
  output mac_op_t     mac_op_o,
  input  logic [31:0] mac_res_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output glyph_req_t  out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIDE,
    ST_NARROW,
    ST_ROW,
    ST_CELL,
    ST_DONE
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  lead_q, lead_d;
  logic        pend_q, pend_d;
  logic [15:0] pen_q, pen_d;
  logic [7:0]  char_q, char_d;
  logic        wide_q, wide_d;
  logic [5:0]  w_q, w_d;
  logic [7:0]  y_q, y_d;
  logic [1:0]  mode_q, mode_d;
  logic [7:0]  stride_q, stride_d;
  logic        out_valid_q, out_valid_d;
  glyph_req_t  out_q, out_d;

  logic        accept;
  logic [15:0] pen_eff;
  logic        pend_eff;
  logic [6:0]  w_round;
  logic [15:0] row_idx;
  logic [15:0] col_idx;
  logic [9:0]  bytes_sat;

  function automatic logic [5:0] clamp_dim(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (v == 6'd0) r = 6'd1;
    else if (v > DimMax) r = DimMax;
    return r;
  endfunction

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign pen_eff  = string_start_i ? start_x_i : pen_q;
  assign pend_eff = pend_q && !string_start_i;
  assign w_round  = {1'b0, w_q} + 7'd7;
  assign row_idx  = {8'd0, lead_q} - {8'd0, RowBase};
  assign col_idx  = {8'd0, char_q} - {8'd0, RowBase};
  assign bytes_sat = ({2'b00, stride_q} > GlyphMaxBytes) ? GlyphMaxBytes
                                                          : {2'b00, stride_q};

  // operand select for the shared unit
  always_comb begin
    mac_op_o = '0;
    unique case (state_q)
      ST_STRIDE: begin
        mac_op_o.a = {13'd0, w_round[5:3]};
        mac_op_o.b = {2'b00, clamp_dim(cfg_i.glyph_height)};
      end
      ST_NARROW: begin
        mac_op_o.a      = {8'd0, char_q};
        mac_op_o.b      = mac_res_i[7:0];
        mac_op_o.addend = cfg_i.ascii_offset;
      end
      ST_ROW: begin
        mac_op_o.a      = row_idx;
        mac_op_o.b      = CellsPerRow;
        mac_op_o.addend = {{16{col_idx[15]}}, col_idx};
      end
      ST_CELL: begin
        mac_op_o.a      = mac_res_i[15:0];
        mac_op_o.b      = stride_q;
        mac_op_o.addend = cfg_i.cjk_offset;
      end
      ST_DONE: begin
        // recirculate the offset while the result register is busy
        mac_op_o.addend = mac_res_i;
      end
      ST_IDLE: mac_op_o = '0;
      default: mac_op_o = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d     = state_q;
    lead_d      = lead_q;
    pend_d      = pend_q;
    pen_d       = pen_q;
    char_d      = char_q;
    wide_d      = wide_q;
    w_d         = w_q;
    y_d         = y_q;
    mode_d      = mode_q;
    stride_d    = stride_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pen_d  = pen_eff;
          pend_d = pend_eff;
          char_d = char_byte_i;
          y_d    = row_y_i;
          mode_d = draw_mode_i;
          if (char_byte_i == 8'd0) begin
            // terminator drops a pending lead byte
            pend_d = 1'b0;
          end else if (pend_eff) begin
            // trail byte completes a wide glyph
            pend_d = 1'b0;
            wide_d = 1'b1;
            w_d    = clamp_dim(cfg_i.cjk_width);
            if (cfg_i.font_loaded) state_d = ST_STRIDE;
          end else if ((char_byte_i & LeadMask) != 8'd0) begin
            lead_d = char_byte_i;
            pend_d = 1'b1;
          end else if (cfg_i.ascii_offset != 32'd0) begin
            wide_d = 1'b0;
            w_d    = clamp_dim(cfg_i.ascii_width);
            if (cfg_i.font_loaded) state_d = ST_STRIDE;
          end
        end
      end
      ST_STRIDE: begin
        state_d = wide_q ? ST_ROW : ST_NARROW;
      end
      ST_NARROW: begin
        stride_d = mac_res_i[7:0];
        state_d  = ST_DONE;
      end
      ST_ROW: begin
        stride_d = mac_res_i[7:0];
        state_d  = ST_CELL;
      end
      ST_CELL: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // load result register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_d.glyph_offset = mac_res_i;
          out_d.glyph_bytes  = bytes_sat[7:0];
          out_d.glyph_width  = w_q;
          out_d.pos_x        = pen_q;
          out_d.pos_y        = y_q;
          out_d.mode_out     = mode_q;
          out_d.is_wide      = wide_q;
          out_d.next_x       = pen_q + {10'd0, w_q};
          out_valid_d        = 1'b1;
          pen_d              = pen_q + {10'd0, w_q};
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lead_q      <= 8'd0;
      pend_q      <= 1'b0;
      pen_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lead_q      <= lead_d;
      pend_q      <= pend_d;
      pen_q       <= pen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    wide_q   <= wide_d;
    w_q      <= w_d;
    y_q      <= y_d;
    mode_q   <= mode_d;
    stride_q <= stride_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> rtl/dgag_glyph_address_top_placeholder.sv
// configuration register file for the glyph address generator
// depends on dgag_pkg; feeds the cfg_t struct to the sequencer
module dgag_cfg_regs import dgag_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FONT_LOADED:  cfg_d.font_loaded  = cfg_wdata_i[0];
        REG_ASCII_WIDTH:  cfg_d.ascii_width  = cfg_wdata_i[5:0];
        REG_CJK_WIDTH:    cfg_d.cjk_width    = cfg_wdata_i[5:0];
        REG_GLYPH_HEIGHT: cfg_d.glyph_height = cfg_wdata_i[5:0];
        REG_ASCII_OFFSET: cfg_d.ascii_offset = cfg_wdata_i;
        REG_CJK_OFFSET:   cfg_d.cjk_offset   = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_loaded  <= 1'b0;
      cfg_q.ascii_width  <= 6'd8;
      cfg_q.cjk_width    <= 6'd16;
      cfg_q.glyph_height <= 6'd16;
      cfg_q.ascii_offset <= 32'd0;
      cfg_q.cjk_offset   <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/dbcs_glyph_address_generator_core.sv
// narrow glyph passes states STRIDE, NARROW, DONE from input transaction to result, wide
// glyph passes STRIDE, ROW, CELL, DONE; no new byte is taken until the glyph leaves DONE,
//   as the shared multiply-add unit computes stride, row*94+cell and cell*stride in turn
// bytes that give no result (terminator, lead byte, skipped glyph) leave the sequencer idle
// reset: asynchronous active low; clears pen, lead byte state and configuration registers to defaults
// depends on dgag_pkg, dgag_cfg_regs, dgag_mac, dgag_ctrl
module dbcs_glyph_address_generator_core import dgag_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  // text byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // char_byte, start_x, row_y, draw_mode, zero pad
  input  logic        s_axis_tuser,  // string_start
  // glyph fetch requests
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // glyph_offset, glyph_bytes, glyph_width, pos_x,
                                     // pos_y, mode_out, next_x
  output logic        m_axis_tuser   // is_wide
);

  cfg_t        cfg;
  mac_op_t     mac_op;
  logic [31:0] mac_res;
  glyph_req_t  req;

  dgag_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dgag_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .res_o (mac_res)
  );

  dgag_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .char_byte_i    (s_axis_tdata[7:0]),
    .string_start_i (s_axis_tuser),
    .start_x_i      (s_axis_tdata[23:8]),
    .row_y_i        (s_axis_tdata[31:24]),
    .draw_mode_i    (s_axis_tdata[33:32]),
    .mac_op_o       (mac_op),
    .mac_res_i      (mac_res),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_o          (req)
  );

  // pack result fields, lowest first
  assign m_axis_tdata = {req.next_x, req.mode_out, req.pos_y, req.pos_x,
                         req.glyph_width, req.glyph_bytes, req.glyph_offset};
  assign m_axis_tuser = req.is_wide;

endmodule

>>> rtl/dgag_checker.sv
// port-level checks for the glyph address generator, bound to the top level
// depends only on the top level's ports
module dgag_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a result never appears right after an input transaction
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result too soon after input transaction");

  // width is clamped to 1..32
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[45:40] != 6'd0) && (m_axis_tdata[45:40] <= 6'd32))
    else $error("glyph width out of range");

  // pen advance matches the reported width
  a_pen_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[87:72] == m_axis_tdata[61:46] + {10'd0, m_axis_tdata[45:40]})
    else $error("next_x does not follow pos_x plus width");

endmodule

bind dbcs_glyph_address_generator_core dgag_checker u_dgag_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/dbcs_glyph_address_generator_core_tb.sv
// testbench for dbcs_glyph_address_generator_core: text byte stream in, glyph fetch requests out
// depends on dgag_pkg and the core; an in-bench predictor checks every result field by field
`timescale 1ns / 100ps

module dbcs_glyph_address_generator_core_tb;
  import dgag_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 12;
  localparam int HoldCycles  = 400;
  localparam int PhaseItems  = 150;
  localparam int NumPhases   = 8;

  // one text byte with its side fields
  typedef struct packed {
    logic [7:0]  char_byte;
    logic        string_start;
    logic [15:0] start_x;
    logic [7:0]  row_y;
    logic [1:0]  draw_mode;
  } text_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // char_byte, start_x, row_y, draw_mode, zero pad
  logic        s_axis_tuser = 1'b0;  // string_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;  // glyph_offset, glyph_bytes, glyph_width, pos_x,
                              // pos_y, mode_out, next_x
  logic        m_axis_tuser;  // is_wide

  // predictor state and register copy
  cfg_t        font_cfg;
  logic [7:0]  held_lead;
  logic        lead_held;
  logic [15:0] pen_pos;

  glyph_req_t  pending_fetches[$];
  int          fetch_errors = 0;
  int          cycle_count = 0;
  int          rx_hold = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;

  dbcs_glyph_address_generator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // zero reads as 1, anything above 32 as 32
  function automatic logic [31:0] limit_dim(input logic [5:0] v);
    if (v == 6'd0) return 32'd1;
    if (v > DimMax) return 32'(DimMax);
    return {26'd0, v};
  endfunction

  // bytes per glyph bitmap for a given clamped width
  function automatic logic [31:0] glyph_stride(input logic [31:0] w);
    return ((w + 32'd7) >> 3) * limit_dim(font_cfg.glyph_height);
  endfunction

  // advance the predictor by one text byte; returns 1 when a fetch request results
  function automatic bit predict_glyph_fetch(input text_item_t it, output glyph_req_t req);
    logic [31:0] w, stride, cell_idx, offs, lead32, byte32, nbytes;
    bit          wide;
    req = '0;
    byte32 = {24'd0, it.char_byte};
    if (it.string_start) begin
      pen_pos = it.start_x;
      lead_held = 1'b0;
    end
    // terminator drops a held lead byte
    if (it.char_byte == 8'h00) begin
      lead_held = 1'b0;
      return 1'b0;
    end
    if (lead_held) begin
      // any nonzero byte completes the pair, indexes wrap below the row base
      lead_held = 1'b0;
      wide = 1'b1;
      w = limit_dim(font_cfg.cjk_width);
      stride = glyph_stride(w);
      lead32 = {24'd0, held_lead};
      cell_idx = (lead32 - RowBase) * CellsPerRow + (byte32 - RowBase);
      offs = cell_idx * stride + font_cfg.cjk_offset;
    end else if ((it.char_byte & LeadMask) != 8'h00) begin
      held_lead = it.char_byte;
      lead_held = 1'b1;
      return 1'b0;
    end else begin
      // narrow table off: glyph skipped, pen stays
      if (font_cfg.ascii_offset == 32'd0) return 1'b0;
      wide = 1'b0;
      w = limit_dim(font_cfg.ascii_width);
      stride = glyph_stride(w);
      offs = byte32 * stride + font_cfg.ascii_offset;
    end
    if (!font_cfg.font_loaded) return 1'b0;
    nbytes = (stride > GlyphMaxBytes) ? 32'(GlyphMaxBytes) : stride;
    req.glyph_offset = offs;
    req.glyph_bytes  = nbytes[7:0];
    req.glyph_width  = w[5:0];
    req.pos_x        = pen_pos;
    req.pos_y        = it.row_y;
    req.mode_out     = it.draw_mode;
    req.is_wide      = wide;
    req.next_x       = pen_pos + w[15:0];
    pen_pos = req.next_x;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fetch_errors++;
      if (fetch_errors <= 10)
        $display("fetch mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  // result side: compare each accepted transaction with the oldest expectation
  always @(posedge clk_i) begin : fetch_checker
    glyph_req_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_fetches.size() == 0) begin
        fetch_errors++;
        if (fetch_errors <= 10)
          $display("unexpected fetch request: tdata 0x%0h tuser %0b", m_axis_tdata,
                   m_axis_tuser);
      end else begin
        want = pending_fetches.pop_front();
        check_field("glyph_offset", want.glyph_offset, m_axis_tdata[31:0]);
        check_field("glyph_bytes", 32'(want.glyph_bytes), 32'(m_axis_tdata[39:32]));
        check_field("glyph_width", 32'(want.glyph_width), 32'(m_axis_tdata[45:40]));
        check_field("pos_x", 32'(want.pos_x), 32'(m_axis_tdata[61:46]));
        check_field("pos_y", 32'(want.pos_y), 32'(m_axis_tdata[69:62]));
        check_field("mode_out", 32'(want.mode_out), 32'(m_axis_tdata[71:70]));
        check_field("next_x", 32'(want.next_x), 32'(m_axis_tdata[87:72]));
        check_field("is_wide", 32'(want.is_wide), 32'(m_axis_tuser));
      end
    end
  end

  // receiver: random stall per result, plus a long hold on request
  initial begin : fetch_receiver
    int  wait_cnt;
    bit  ready_nxt;
    wait_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        wait_cnt = rx_idle_en ? $urandom_range(0, 12) : 0;
      if (rx_hold > 0) begin
        ready_nxt = 1'b0;
        rx_hold--;
      end else if (wait_cnt > 0) begin
        ready_nxt = 1'b0;
        wait_cnt--;
      end else begin
        ready_nxt = 1'b1;
      end
      m_axis_tready <= ready_nxt;
    end
  end

  function automatic text_item_t mk_text(input logic [7:0] c, input bit start,
                                         input logic [15:0] sx, input logic [7:0] y,
                                         input logic [1:0] mode);
    text_item_t it;
    it.char_byte    = c;
    it.string_start = start;
    it.start_x      = sx;
    it.row_y        = y;
    it.draw_mode    = mode;
    return it;
  endfunction

  function automatic text_item_t random_text(input logic [7:0] c, input bit start);
    return mk_text(c, start, 16'($urandom), 8'($urandom), 2'($urandom));
  endfunction

  // one input transaction, preceded by a random gap
  task automatic send_text(input text_item_t it);
    int         gap;
    glyph_req_t req;
    gap = tx_idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, it.draw_mode, it.row_y, it.start_x, it.char_byte};
    s_axis_tuser  <= it.string_start;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_glyph_fetch(it, req)) pending_fetches.push_back(req);
  endtask

  // stop sending, let all expected results drain, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_fetches.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_FONT_LOADED:  font_cfg.font_loaded  = val[0];
      REG_ASCII_WIDTH:  font_cfg.ascii_width  = val[5:0];
      REG_CJK_WIDTH:    font_cfg.cjk_width    = val[5:0];
      REG_GLYPH_HEIGHT: font_cfg.glyph_height = val[5:0];
      REG_ASCII_OFFSET: font_cfg.ascii_offset = val;
      REG_CJK_OFFSET:   font_cfg.cjk_offset   = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(REG_FONT_LOADED, {31'd0, s.font_loaded});
    write_reg(REG_ASCII_WIDTH, {26'd0, s.ascii_width});
    write_reg(REG_CJK_WIDTH, {26'd0, s.cjk_width});
    write_reg(REG_GLYPH_HEIGHT, {26'd0, s.glyph_height});
    write_reg(REG_ASCII_OFFSET, s.ascii_offset);
    write_reg(REG_CJK_OFFSET, s.cjk_offset);
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t mk_cfg(input logic fl, input logic [5:0] aw, input logic [5:0] cw,
                                  input logic [5:0] gh, input logic [31:0] ao,
                                  input logic [31:0] co);
    cfg_t s;
    s.font_loaded  = fl;
    s.ascii_width  = aw;
    s.cjk_width    = cw;
    s.glyph_height = gh;
    s.ascii_offset = ao;
    s.cjk_offset   = co;
    return s;
  endfunction

  // dimension register value, leaning on the clamp corners
  function automatic logic [5:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd63;
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  function automatic logic [31:0] pick_offset(input bit allow_zero);
    case ($urandom_range(0, 5))
      0: return allow_zero ? 32'd0 : 32'd1;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // font off after reset: pairing tracked, no results; then reset widths with font on
  task automatic test_reset_defaults();
    send_text(mk_text(8'h41, 1'b1, 16'd0, 8'd5, 2'd0));
    send_text(mk_text(8'hB0, 1'b0, 16'd0, 8'd5, 2'd0));
    send_text(mk_text(8'hA1, 1'b0, 16'd0, 8'd5, 2'd0));
    send_text(mk_text(8'hB0, 1'b0, 16'd0, 8'd5, 2'd1));
    wait_idle();
    write_reg(REG_FONT_LOADED, 32'd1);
    cfg_we_i <= 1'b0;
    // trail of the lead held over the register write
    send_text(mk_text(8'hA1, 1'b0, 16'd0, 8'd5, 2'd1));
    send_text(mk_text(8'h41, 1'b0, 16'd0, 8'd5, 2'd2));
    send_text(mk_text(8'hB0, 1'b0, 16'd0, 8'd5, 2'd3));
    send_text(mk_text(8'hA2, 1'b0, 16'd0, 8'd5, 2'd3));
  endtask

  // byte classes, field extremes and lead byte corner cases
  task automatic test_glyph_decode();
    wait_idle();
    load_settings(mk_cfg(1'b1, 6'd8, 6'd16, 6'd16, 32'h0000_1000, 32'h0002_0000));
    send_text(mk_text(8'h41, 1'b1, 16'd0, 8'd0, 2'd0));
    send_text(mk_text(8'h7F, 1'b0, 16'd0, 8'hFF, 2'd1));
    send_text(mk_text(8'h01, 1'b0, 16'd0, 8'h80, 2'd2));
    send_text(mk_text(8'hA1, 1'b0, 16'd0, 8'h01, 2'd3));
    send_text(mk_text(8'hA1, 1'b0, 16'd0, 8'h01, 2'd3));
    send_text(mk_text(8'hFE, 1'b0, 16'd0, 8'h7F, 2'd3));
    send_text(mk_text(8'hFE, 1'b0, 16'd0, 8'h7F, 2'd0));
    // trail with bit 7 clear, lead below the row base
    send_text(mk_text(8'h80, 1'b0, 16'd0, 8'd3, 2'd1));
    send_text(mk_text(8'h01, 1'b0, 16'd0, 8'd3, 2'd1));
    send_text(mk_text(8'hFF, 1'b0, 16'd0, 8'd3, 2'd2));
    send_text(mk_text(8'hFF, 1'b0, 16'd0, 8'd3, 2'd2));
    // terminator drops the lead, next byte is narrow
    send_text(mk_text(8'hB0, 1'b0, 16'd0, 8'd4, 2'd0));
    send_text(mk_text(8'h00, 1'b0, 16'd0, 8'd4, 2'd0));
    send_text(mk_text(8'h41, 1'b0, 16'd0, 8'd4, 2'd0));
    // string start drops the lead; pen wraps past 16 bits
    send_text(mk_text(8'hC4, 1'b0, 16'd0, 8'd4, 2'd1));
    send_text(mk_text(8'h42, 1'b1, 16'hFFF8, 8'd9, 2'd1));
    send_text(mk_text(8'h43, 1'b0, 16'hFFF8, 8'd9, 2'd2));
    send_text(mk_text(8'h00, 1'b0, 16'd0, 8'd9, 2'd2));
    // lead on the first byte of a string
    send_text(mk_text(8'hD6, 1'b1, 16'h1234, 8'd10, 2'd3));
    send_text(mk_text(8'hD0, 1'b0, 16'h5555, 8'd10, 2'd3));
  endtask

  // clamped sizes, wrapping offsets, narrow table off, font off
  task automatic test_register_extremes();
    wait_idle();
    load_settings(mk_cfg(1'b1, 6'd0, 6'd0, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_text(mk_text(8'h7F, 1'b1, 16'hAAAA, 8'd1, 2'd0));
    send_text(mk_text(8'hF7, 1'b0, 16'd0, 8'd1, 2'd1));
    send_text(mk_text(8'hFE, 1'b0, 16'd0, 8'd1, 2'd1));
    wait_idle();
    load_settings(mk_cfg(1'b1, 6'd63, 6'd63, 6'd63, 32'hFFFF_FF00, 32'hFFFF_0000));
    send_text(mk_text(8'h7F, 1'b0, 16'd0, 8'd2, 2'd2));
    send_text(mk_text(8'hFF, 1'b0, 16'd0, 8'd2, 2'd3));
    send_text(mk_text(8'hFF, 1'b0, 16'd0, 8'd2, 2'd3));
    wait_idle();
    load_settings(mk_cfg(1'b1, 6'd32, 6'd1, 6'd32, 32'd0, 32'h0000_0100));
    send_text(mk_text(8'h41, 1'b0, 16'd0, 8'd3, 2'd0));
    send_text(mk_text(8'hA1, 1'b0, 16'd0, 8'd3, 2'd0));
    send_text(mk_text(8'h41, 1'b0, 16'd0, 8'd3, 2'd1));
    wait_idle();
    load_settings(mk_cfg(1'b0, 6'd32, 6'd32, 6'd32, 32'h10, 32'h20));
    send_text(mk_text(8'hB1, 1'b0, 16'd0, 8'd4, 2'd0));
    send_text(mk_text(8'hB2, 1'b0, 16'd0, 8'd4, 2'd0));
    send_text(mk_text(8'h30, 1'b0, 16'd0, 8'd4, 2'd0));
    send_text(mk_text(8'hB3, 1'b0, 16'd0, 8'd4, 2'd0));
  endtask

  // receiver holds off while the sender streams glyphs back to back
  task automatic test_input_stall();
    int n;
    wait_idle();
    load_settings(mk_cfg(1'b1, 6'd8, 6'd16, 6'd16, 32'h0000_0800, 32'h0001_0000));
    tx_idle_en = 1'b0;
    rx_hold = HoldCycles;
    for (n = 0; n < 30; n++) begin
      send_text(random_text(8'($urandom_range(1, 127)), n == 0));
      send_text(random_text(8'($urandom_range(8'hA1, 8'hF7)), 1'b0));
      send_text(random_text(8'($urandom_range(8'hA1, 8'hFE)), 1'b0));
    end
    tx_idle_en = 1'b1;
  endtask

  // mostly well-formed strings with random content, some noise and broken pairs
  task automatic test_random_text();
    int   phase, sent;
    cfg_t s;
    for (phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      case (phase)
        0: s = mk_cfg(1'b1, 6'd1, 6'd1, 6'd1, 32'd1, 32'd0);
        1: s = mk_cfg(1'b1, 6'd32, 6'd32, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: s = mk_cfg($urandom_range(0, 7) != 0, pick_dim(), pick_dim(), pick_dim(),
                            pick_offset(1'b1), pick_offset(1'b0));
      endcase
      load_settings(s);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PhaseItems) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            send_text(random_text(8'($urandom_range(1, 127)), $urandom_range(0, 15) == 0));
            sent += 1;
          end
          4, 5, 6: begin
            send_text(random_text(8'($urandom_range(8'hA1, 8'hF7)),
                                  $urandom_range(0, 15) == 0));
            send_text(random_text(8'($urandom_range(8'hA1, 8'hFE)), 1'b0));
            sent += 2;
          end
          7: begin
            // end of string, then a new one
            send_text(random_text(8'h00, 1'b0));
            send_text(random_text(8'($urandom_range(1, 127)), 1'b1));
            sent += 2;
          end
          8: begin
            send_text(random_text(8'($urandom_range(0, 255)), $urandom_range(0, 1)));
            sent += 1;
          end
          default: begin
            // lead cut off by a terminator or a new string
            send_text(random_text(8'($urandom_range(128, 255)), 1'b0));
            if ($urandom_range(0, 1) != 0)
              send_text(random_text(8'h00, 1'b0));
            else
              send_text(random_text(8'($urandom_range(0, 255)), 1'b1));
            sent += 2;
          end
        endcase
      end
    end
  endtask

  initial begin
    font_cfg  = mk_cfg(1'b0, 6'd8, 6'd16, 6'd16, 32'd0, 32'd0);
    held_lead = 8'd0;
    lead_held = 1'b0;
    pen_pos   = 16'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_glyph_decode();
    test_register_extremes();
    test_input_stall();
    test_random_text();
    wait_idle();
    if (fetch_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
